// ===== rtl/core/lmbg_pkg.sv =====
// Package for the LED matrix bar-graph scanner.
// Holds the beat types, command codes and level conversion constants.
// No dependencies.
package lmbg_pkg;

  localparam int unsigned AdcW   = 12;
  localparam int unsigned NumW   = 23;
  localparam int unsigned LevelW = 7;
  localparam int unsigned ColW   = 3;
  localparam int unsigned ByteW  = 8;

  localparam logic [NumW-1:0]   LVL_GAIN   = NumW'(1760);
  localparam logic [NumW-1:0]   LVL_OFFSET = NumW'(3276000);
  localparam logic [NumW-1:0]   LVL_SAT    = NumW'(64 * 4095);
  localparam logic [LevelW-1:0] LVL_MAX    = LevelW'(64);

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_REFRESH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic            cmd;
    logic [AdcW-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic column_bit;
    logic row_bit;
    logic latch;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] col_byte;
    logic [ByteW-1:0] row_byte;
  } ser_load_t;

  typedef struct packed {
    logic busy;
    logic can_load;
  } ser_status_t;

  function automatic logic [ByteW-1:0] row_byte_f(logic [LevelW-1:0] level,
                                                   logic [ColW-1:0] col);
    logic signed [ByteW:0] leds;
    logic [ByteW-1:0]      res;
    leds = $signed({2'b00, level}) - $signed({3'b000, col, 3'b000});
    if (leds <= 0) begin
      res = '0;
    end else if (leds >= 8) begin
      res = '1;
    end else begin
      res = {ByteW{1'b1}} << (4'd8 - 4'(leds[3:0]));
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/lmbg_in_stage.sv =====
// Input register stage of the scanner: holds one beat and the scaled ADC product.
// Depends on lmbg_pkg.
module lmbg_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lmbg_pkg::in_item_t      in_data_i,
  input  logic                    consume_i,
  output logic                    stage_valid_o,
  output logic                    stage_cmd_o,
  output logic [lmbg_pkg::NumW-1:0] stage_num_o
);
  import lmbg_pkg::*;

  logic            valid_q, valid_d;
  logic            cmd_q;
  logic [NumW-1:0] num_q;
  logic            take;

  assign in_ready_o = !valid_q || consume_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= in_data_i.cmd;
      num_q <= NumW'(in_data_i.adc_sample) * LVL_GAIN;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_cmd_o   = cmd_q;
  assign stage_num_o   = num_q;

endmodule

// ===== rtl/core/lmbg_level.sv =====
// Bar level conversion: floor((num - offset) / 4095) clamped to 0..64.
// Depends on lmbg_pkg.
module lmbg_level (
  input  logic [lmbg_pkg::NumW-1:0]   num_i,
  output logic [lmbg_pkg::LevelW-1:0] level_o
);
  import lmbg_pkg::*;

  logic [NumW-1:0] diff;
  logic [17:0]     d;
  logic [18:0]     sum;

  assign diff = num_i - LVL_OFFSET;
  assign d    = diff[17:0];
  assign sum  = 19'(d) + 19'(d >> 12) + 19'd1;

  always_comb begin
    if (num_i <= LVL_OFFSET) begin
      level_o = '0;
    end else if (diff >= LVL_SAT) begin
      level_o = LVL_MAX;
    end else begin
      level_o = sum[18:12];
    end
  end

endmodule

// ===== rtl/core/lmbg_serializer.sv =====
// Column serializer: shifts the column and row bytes out MSB first, latch on bit 8.
// Depends on lmbg_pkg.
module lmbg_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lmbg_pkg::ser_load_t   load_i,
  output lmbg_pkg::ser_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lmbg_pkg::out_item_t   out_data_o
);
  import lmbg_pkg::*;

  logic             busy_q, busy_d;
  logic [ColW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] col_q, row_q;
  logic             last;
  logic             beat;

  assign last = &cnt_q;
  assign beat = busy_q && out_ready_i;

  assign status_o.busy     = busy_q;
  assign status_o.can_load = !busy_q || (beat && last);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (beat) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i.valid) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      col_q <= load_i.col_byte;
      row_q <= load_i.row_byte;
    end else if (beat) begin
      col_q <= col_q << 1;
      row_q <= row_q << 1;
    end
  end

  assign out_valid_o           = busy_q;
  assign out_data_o.column_bit = col_q[ByteW-1];
  assign out_data_o.row_bit    = row_q[ByteW-1];
  assign out_data_o.latch      = last;

endmodule

// ===== rtl/core/led_matrix_bar_graph_scanner_core.sv =====
// LED matrix bar-graph scanner, top level.
// Uses lmbg_pkg, lmbg_in_stage, lmbg_level and lmbg_serializer.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): a sample beat (cmd 0)
// sets the stored bar level from a 12-bit ADC count; a refresh beat (cmd 1)
// scans the next matrix column.
// Output channel (out_valid_o/out_ready_i/out_data_o): a refresh yields
// eight beats, MSB first, pairing a column-select bit with a row bit; the
// eighth carries latch. The column counter advances modulo 8 when a
// refresh loads the serializer. Each beat is held in the input register;
// a sample updates the level as it leaves it, a refresh loads the
// serializer and its first result appears in the cycle after the load.
// Throughput: one sample per cycle while no refresh waits in the input
// register. A refresh occupies the serializer for eight output beats; the
// next one can load as the last beat is taken. Samples pass while a column
// is shifting. Reset clears the bar level (all LEDs off), the column
// counter and all valid state. On a receiver stall the current beat holds,
// a refresh fills the one-entry input register and in_ready_o drops.
module led_matrix_bar_graph_scanner_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lmbg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lmbg_pkg::out_item_t out_data_o
);
  import lmbg_pkg::*;

  logic              stage_valid;
  logic              stage_cmd;
  logic [NumW-1:0]   stage_num;
  logic              consume;
  logic              is_refresh;
  logic [LevelW-1:0] new_level;
  logic [LevelW-1:0] level_q;
  logic [ColW-1:0]   col_q;
  ser_load_t         load;
  ser_status_t       ser_status;

  lmbg_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .consume_i     (consume),
    .stage_valid_o (stage_valid),
    .stage_cmd_o   (stage_cmd),
    .stage_num_o   (stage_num)
  );

  lmbg_level u_level (
    .num_i   (stage_num),
    .level_o (new_level)
  );

  assign is_refresh = (stage_cmd == CMD_REFRESH);
  assign consume    = stage_valid && (!is_refresh || ser_status.can_load);

  assign load.valid    = consume && is_refresh;
  assign load.col_byte = ByteW'(1) << col_q;
  assign load.row_byte = row_byte_f(level_q, col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      col_q   <= '0;
    end else if (consume) begin
      if (is_refresh) begin
        col_q <= col_q + 1'b1;
      end else begin
        level_q <= new_level;
      end
    end
  end

  lmbg_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .status_o    (ser_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/lmbg_checker.sv =====
// Port-level checks for the scanner, bound to the top level.
// Depends on lmbg_pkg and led_matrix_bar_graph_scanner_core.
module lmbg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input lmbg_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lmbg_pkg::out_item_t out_data_o
);
  import lmbg_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.latch |=> out_valid_o)
    else $error("column run broke before latch");

  a_latch_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.latch |=> !out_data_o.latch)
    else $error("latch repeated on consecutive beats");

endmodule

bind led_matrix_bar_graph_scanner_core lmbg_checker u_lmbg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for led_matrix_bar_graph_scanner_core.
// Runs a directed table, then random sample/refresh beats, and checks each serial
// beat against a local level and row-mask predictor. Depends on lmbg_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmbg_pkg::*;

  localparam int unsigned GAIN        = 1760;
  localparam int unsigned OFFSET      = 3276000;
  localparam int unsigned DIVISOR     = 4095;
  localparam int unsigned FULL_LEVEL  = 64;
  localparam int          NUM_DIR     = 24;
  localparam int          NUM_RAND    = 356;
  localparam int          STEADY_LO   = 150;
  localparam int          STEADY_HI   = 230;
  localparam int          HOLD_AFTER  = 300;
  localparam int          HOLD_CYCLES = 160;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          DRAIN_PAD   = 20;

  typedef struct packed {
    logic       typed;
    logic [7:0] col_ref;
    logic [7:0] row_ref;
    cmd_e       cmd;
    logic [11:0] adc;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  logic [6:0] bar_lvl  = '0;
  logic [2:0] next_col = '0;
  out_item_t  scan_bits_due [$];
  logic       steady   = 1'b0;
  int         errors   = 0;
  int         beats_in = 0;
  int         scans    = 0;
  int         beats_out = 0;

  dir_row_t dir_tab [NUM_DIR] = '{
    '{1'b1, 8'h01, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd4095},
    '{1'b1, 8'h02, 8'hFF, CMD_REFRESH, 12'hFFF},
    '{1'b1, 8'h04, 8'hFF, CMD_REFRESH, 12'h000},
    '{1'b1, 8'h08, 8'hFF, CMD_REFRESH, 12'hFFF},
    '{1'b1, 8'h10, 8'hFF, CMD_REFRESH, 12'h000},
    '{1'b1, 8'h20, 8'hFF, CMD_REFRESH, 12'hAAA},
    '{1'b1, 8'h40, 8'hFF, CMD_REFRESH, 12'h555},
    '{1'b1, 8'h80, 8'hFF, CMD_REFRESH, 12'h000},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd2010},
    '{1'b0, 8'h00, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd1890},
    '{1'b0, 8'h00, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd1861},
    '{1'b1, 8'h04, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd1862},
    '{1'b0, 8'h00, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd2011},
    '{1'b0, 8'h00, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd2048},
    '{1'b0, 8'h00, 8'h00, CMD_REFRESH, 12'd0},
    '{1'b0, 8'h00, 8'h00, CMD_SAMPLE,  12'd1864},
    '{1'b0, 8'h00, 8'h00, CMD_REFRESH, 12'd0}
  };

  led_matrix_bar_graph_scanner_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [6:0] level_of_count(logic [11:0] count);
    int unsigned num;
    int unsigned q;
    num = int'(count) * GAIN;
    if (num <= OFFSET) return 7'd0;
    q = (num - OFFSET) / DIVISOR;
    if (q > FULL_LEVEL) q = FULL_LEVEL;
    return q[6:0];
  endfunction

  function automatic logic [7:0] lit_rows(logic [6:0] lvl, logic [2:0] col);
    int leds;
    leds = int'(lvl) - 8 * int'(col);
    if (leds <= 0) return 8'h00;
    if (leds >= 8) return 8'hFF;
    return 8'hFF << (8 - leds);
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    b.adc_sample = 12'($urandom_range(4095));
    b.cmd = ($urandom_range(99) < 55) ? CMD_REFRESH : CMD_SAMPLE;
    if (b.cmd == CMD_SAMPLE && $urandom_range(99) < 75) begin
      b.adc_sample = 12'($urandom_range(2020, 1855));
    end
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then update the predicted state.
  task automatic push_beat(input in_item_t b, input logic typed,
                           input logic [7:0] col_t, input logic [7:0] row_t);
    logic       taken;
    logic [7:0] cb;
    logic [7:0] rb;
    taken = 1'b0;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    beats_in++;
    if (b.cmd == CMD_SAMPLE) begin
      bar_lvl = level_of_count(b.adc_sample);
    end else begin
      cb = 8'd1 << next_col;
      rb = lit_rows(bar_lvl, next_col);
      if (typed) begin
        cb = col_t;
        rb = row_t;
      end
      for (int k = 7; k >= 0; k--) begin
        scan_bits_due.push_back('{column_bit: cb[k], row_bit: rb[k], latch: (k == 0)});
      end
      next_col = next_col + 3'd1;
      scans++;
    end
  endtask

  task automatic idle_gap();
    while (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    in_item_t b;
    wait (rst_ni);
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      idle_gap();
      b.cmd        = dir_tab[i].cmd;
      b.adc_sample = dir_tab[i].adc;
      push_beat(b, dir_tab[i].typed, dir_tab[i].col_ref, dir_tab[i].row_ref);
    end
    for (int n = 0; n < NUM_RAND; n++) begin
      steady = (n >= STEADY_LO) && (n < STEADY_HI);
      idle_gap();
      push_beat(random_beat(), 1'b0, 8'h00, 8'h00);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (scan_bits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
    $display("testbench: %0d input beats (%0d column scans), %0d serial beats checked",
             beats_in, scans, beats_out);
    $display("testbench: levels 0 to 64, all eight columns, wrap, stalls on both sides");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    logic held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && beats_out >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (scan_bits_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none got %b", $time, out_data_o);
        errors++;
      end else begin
        want = scan_bits_due.pop_front();
        if (out_data_o.column_bit !== want.column_bit) begin
          $display("%0t: column_bit expected %b got %b", $time, want.column_bit,
                   out_data_o.column_bit);
          errors++;
        end
        if (out_data_o.row_bit !== want.row_bit) begin
          $display("%0t: row_bit expected %b got %b", $time, want.row_bit,
                   out_data_o.row_bit);
          errors++;
        end
        if (out_data_o.latch !== want.latch) begin
          $display("%0t: latch expected %b got %b", $time, want.latch, out_data_o.latch);
          errors++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/lmbg_pkg.sv
rtl/core/lmbg_in_stage.sv
rtl/core/lmbg_level.sv
rtl/core/lmbg_serializer.sv
rtl/core/led_matrix_bar_graph_scanner_core.sv
rtl/core/lmbg_checker.sv
tb/testbench.sv
